/* src/crc_checked_frame_receiver_defines.svh */
// assertion macros for the crc checked frame receiver
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CCFR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccfr assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define CCFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccfr assertion failed");

`endif

/* src/ccfr_pkg.sv */
// shared types, constants and the crc-32 byte update for the frame receiver
package ccfr_pkg;

  localparam int OVERHEAD_BYTES = 16;
  localparam int CFG_INDEX_W    = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [15:0] HEADER_WORD_RESET = 16'h0000;
  localparam logic [15:0] MAX_LEN_RESET     = 16'd1024;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_WORD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN     = 8'd1;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  localparam logic [1:0] HDR_NONE  = 2'd0;
  localparam logic [1:0] HDR_FIRST = 2'd1;
  localparam logic [1:0] HDR_BOTH  = 2'd2;

  typedef struct packed {
    logic [15:0] header_word;
    logic [15:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        status;
    logic [7:0]  version;
    logic [7:0]  frame_number;
    logic [15:0] frame_length;
    logic [7:0]  source_address;
    logic [7:0]  destination_address;
    logic [31:0] command_word;
    logic        end_of_frame;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/crc_checked_frame_receiver.sv */
// top level: byte stream deframer with crc-32 check
// a result is presented from the result register, after the beat that causes it has passed the input register
// throughput: one byte beat per cycle while the result register is not stalled, set by the byte-wide crc update
// a stalled result register holds one result while the input register takes one more beat
// reset: synchronous rst clears the parser state, crc to all ones and config to defaults
`include "crc_checked_frame_receiver_defines.svh"
module crc_checked_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // payload_byte, status, version, frame_number, frame_length,
  // source_address, destination_address, command_word, zero fill
  output logic [95:0]                       m_tdata,
  output logic                              m_tuser,   // kind
  output logic                              m_tlast,   // end_of_frame
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data
);

  ccfr_pkg::cfg_t    cfg;
  ccfr_pkg::result_t res;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              take;

  ccfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccfr_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .take     (take)
  );

  ccfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .take      (take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {7'b0000000, res.command_word, res.destination_address,
                    res.source_address, res.frame_length, res.frame_number,
                    res.version, res.status, res.payload_byte};
  assign m_tuser = res.kind;
  assign m_tlast = res.end_of_frame;

  `CCFR_ASSERT_IMPLIES(a_last_is_frame_end, m_tvalid, m_tlast == m_tuser)
  `CCFR_ASSERT_IMPLIES(a_payload_fields_zero, m_tvalid && (m_tuser == ccfr_pkg::KIND_PAYLOAD),
                       m_tdata[95:8] == 88'd0)
  `CCFR_ASSERT_IMPLIES(a_stall_only_when_full, !s_tready, in_valid && !take)
  `CCFR_ASSERT_NEXT(a_stalled_input_kept, in_valid && !take, in_valid)

endmodule

/* src/ccfr_cfg.sv */
// configuration registers: header word and maximum frame length
module ccfr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data,
  output ccfr_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_word      <= ccfr_pkg::HEADER_WORD_RESET;
      cfg.max_frame_length <= ccfr_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ccfr_pkg::CFG_HEADER_WORD) begin
        cfg.header_word <= cfg_data;
      end else if (cfg_index == ccfr_pkg::CFG_MAX_LEN) begin
        cfg.max_frame_length <= cfg_data;
      end
    end
  end

endmodule

/* src/ccfr_in_reg.sv */
// input register stage for received byte beats
module ccfr_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  output logic       in_valid,
  output logic [7:0] in_byte,
  input  logic       take
);

  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

/* src/ccfr_parser.sv */
// frame parser: header hunt, field capture, crc update and result register
module ccfr_parser (
  input  logic              clk,
  input  logic              rst,
  input  ccfr_pkg::cfg_t    cfg,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              take,
  output logic              out_valid,
  input  logic              out_ready,
  output ccfr_pkg::result_t out_data
);

  logic [1:0]  hdr_matched, hdr_matched_next;
  logic [15:0] byte_pos, byte_pos_next;
  logic [15:0] exp_len, exp_len_next;
  logic [31:0] crc, crc_next;
  logic [31:0] cap_crc, cap_crc_next;
  logic [7:0]  cap_version, cap_version_next;
  logic [7:0]  cap_number, cap_number_next;
  logic [7:0]  cap_source, cap_source_next;
  logic [7:0]  cap_dest, cap_dest_next;
  logic [31:0] cap_command, cap_command_next;

  logic              res_valid;
  ccfr_pkg::result_t res;

  logic [7:0]  want;
  logic [15:0] len_new;
  logic [15:0] pos_inc;
  logic [16:0] pos_plus4;
  logic [16:0] pos_plus1;
  logic [31:0] crc_upd;
  logic [31:0] final_crc;

  assign take      = in_valid && (!out_valid || out_ready);
  assign want      = (hdr_matched == ccfr_pkg::HDR_NONE) ? cfg.header_word[15:8]
                                                         : cfg.header_word[7:0];
  assign len_new   = {exp_len[15:8], in_byte};
  assign pos_inc   = byte_pos + 16'd1;
  assign pos_plus4 = {1'b0, byte_pos} + 17'd4;
  assign pos_plus1 = {1'b0, byte_pos} + 17'd1;
  assign crc_upd   = ccfr_pkg::crc_byte(crc, in_byte);
  assign final_crc = crc ^ ccfr_pkg::CRC_INIT;

  always_comb begin
    hdr_matched_next = hdr_matched;
    byte_pos_next    = byte_pos;
    exp_len_next     = exp_len;
    crc_next         = crc;
    cap_crc_next     = cap_crc;
    cap_version_next = cap_version;
    cap_number_next  = cap_number;
    cap_source_next  = cap_source;
    cap_dest_next    = cap_dest;
    cap_command_next = cap_command;
    res_valid        = 1'b0;
    res              = '0;

    if (hdr_matched != ccfr_pkg::HDR_BOTH) begin
      if (in_byte == want) begin
        if (hdr_matched == ccfr_pkg::HDR_FIRST) begin
          hdr_matched_next = ccfr_pkg::HDR_BOTH;
          byte_pos_next    = 16'd2;
          crc_next         = ccfr_pkg::CRC_INIT;
          cap_crc_next     = '0;
        end else begin
          hdr_matched_next = ccfr_pkg::HDR_FIRST;
        end
      end else begin
        hdr_matched_next = ccfr_pkg::HDR_NONE;
      end
    end else begin
      byte_pos_next = pos_inc;
      priority if (byte_pos == 16'd2) begin
        cap_version_next = in_byte;
      end else if (byte_pos < 16'd6) begin
        crc_next = crc_upd;
        priority if (byte_pos == 16'd3) begin
          cap_number_next = in_byte;
        end else if (byte_pos == 16'd4) begin
          exp_len_next = {in_byte, 8'h00};
        end else begin
          exp_len_next = len_new;
          if (len_new < 16'(ccfr_pkg::OVERHEAD_BYTES) || len_new > cfg.max_frame_length) begin
            hdr_matched_next = ccfr_pkg::HDR_NONE;
            byte_pos_next    = '0;
          end
        end
      end else if (pos_plus4 < {1'b0, exp_len}) begin
        crc_next = crc_upd;
        priority if (byte_pos == 16'd6) begin
          cap_source_next = in_byte;
        end else if (byte_pos == 16'd7) begin
          cap_dest_next = in_byte;
        end else if (byte_pos < 16'd12) begin
          cap_command_next = {cap_command[23:0], in_byte};
        end else begin
          res_valid        = 1'b1;
          res.kind         = ccfr_pkg::KIND_PAYLOAD;
          res.payload_byte = in_byte;
        end
      end else begin
        cap_crc_next = {cap_crc[23:0], in_byte};
        if (pos_plus1 >= {1'b0, exp_len}) begin
          res_valid               = 1'b1;
          res.kind                = ccfr_pkg::KIND_FRAME_END;
          res.status              = (final_crc != cap_crc_next) ? ccfr_pkg::STATUS_CRC_ERR
                                                                : ccfr_pkg::STATUS_OK;
          res.version             = cap_version;
          res.frame_number        = cap_number;
          res.frame_length        = exp_len;
          res.source_address      = cap_source;
          res.destination_address = cap_dest;
          res.command_word        = cap_command;
          res.end_of_frame        = 1'b1;
          hdr_matched_next        = ccfr_pkg::HDR_NONE;
          byte_pos_next           = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_matched <= ccfr_pkg::HDR_NONE;
      byte_pos    <= '0;
      exp_len     <= '0;
      crc         <= ccfr_pkg::CRC_INIT;
      cap_crc     <= '0;
      cap_version <= '0;
      cap_number  <= '0;
      cap_source  <= '0;
      cap_dest    <= '0;
      cap_command <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        hdr_matched <= hdr_matched_next;
        byte_pos    <= byte_pos_next;
        exp_len     <= exp_len_next;
        crc         <= crc_next;
        cap_crc     <= cap_crc_next;
        cap_version <= cap_version_next;
        cap_number  <= cap_number_next;
        cap_source  <= cap_source_next;
        cap_dest    <= cap_dest_next;
        cap_command <= cap_command_next;
      end
      if (take && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data <= res;
    end
  end

endmodule
